FILE: rtl/rsct_pkg.sv
// Shared types, codes and state encoding for the ranked score table.
package rsct_pkg;

  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_RANK   = 2'd2;
  localparam logic [1:0] MODE_TOP    = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        player_id;
    logic signed [63:0] score;
    logic [6:0]         top_count;
  } req_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         rank;
    logic [31:0]        entry_id;
    logic signed [63:0] entry_score;
    logic               last;
  } rsp_word_t;

  typedef struct packed {
    logic [31:0]        id;
    logic signed [63:0] score;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_FIND_DONE,
    S_DEL_RD,
    S_DEL_WR,
    S_INS_RD,
    S_INS_CHK,
    S_SH_RD,
    S_SH_WR,
    S_TOP_RD,
    S_TOP_CHK,
    S_EMIT
  } state_t;

endpackage

FILE: rtl/rsct_ram.sv
// Generic simple dual-port RAM with registered read.
module rsct_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/ranked_score_table.sv
// Ranked score table: sorted (id, score) slots held in one RAM.
// Rank query: a lookup walk over the slots; remove also walks the slots below the entry.
// Update: lookup, delete and insert walks over the single-port-read slot RAM.
// Top: one slot read per result word.
// One word is worked at a time; a finished word waits in the output register.
// Reset (synchronous) empties the table at once; slot contents are not cleared.
module ranked_score_table #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  rsct_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rsct_pkg::rsp_word_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rsct_pkg::state_t    state, state_next;
  rsct_pkg::req_word_t q, q_next;
  rsct_pkg::rsp_word_t res, res_next;
  rsct_pkg::rsp_word_t rsp_next;
  logic                rsp_valid_next;
  logic [CW-1:0]       idx, idx_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic [CW-1:0]       pos, pos_next;
  logic [CW-1:0]       n_top, n_top_next;
  logic                hit, hit_next;
  logic signed [63:0]  old, old_next;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  rsct_pkg::slot_t     ram_wdata, ram_rdata;
  logic                out_free;
  logic [CW-1:0]       idx_inc, idx_dec;

  assign out_free = !rsp_valid || !rsp_stall;
  assign idx_inc  = idx + CW'(1);
  assign idx_dec  = idx - CW'(1);

  rsct_ram #(.WIDTH($bits(rsct_pkg::slot_t)), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next     = state;
    q_next         = q;
    res_next       = res;
    idx_next       = idx;
    cnt_next       = cnt;
    pos_next       = pos;
    n_top_next     = n_top;
    hit_next       = hit;
    old_next       = old;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    case (state)
      rsct_pkg::S_IDLE: begin
        if (req_valid) begin
          q_next   = req;
          idx_next = '0;
          hit_next = 1'b0;
          if (req.mode == rsct_pkg::MODE_TOP) begin
            n_top_next = (req.top_count < 7'(cnt)) ? CW'(req.top_count) : cnt;
            if (cnt == '0) begin
              res_next   = '{rsct_pkg::STATUS_NOTFOUND, 7'd0, 32'd0, 64'sd0, 1'b1};
              state_next = rsct_pkg::S_EMIT;
            end else if (req.top_count == 7'd0) begin
              state_next = rsct_pkg::S_IDLE;
            end else begin
              state_next = rsct_pkg::S_TOP_RD;
            end
          end else if (cnt == '0) begin
            state_next = rsct_pkg::S_FIND_DONE;
          end else begin
            state_next = rsct_pkg::S_FIND_RD;
          end
        end
      end
      rsct_pkg::S_FIND_RD: state_next = rsct_pkg::S_FIND_CHK;
      rsct_pkg::S_FIND_CHK: begin
        if (ram_rdata.id == q.player_id) begin
          hit_next   = 1'b1;
          pos_next   = idx;
          old_next   = ram_rdata.score;
          state_next = rsct_pkg::S_FIND_DONE;
        end else if (idx_inc >= cnt) begin
          state_next = rsct_pkg::S_FIND_DONE;
        end else begin
          idx_next   = idx_inc;
          state_next = rsct_pkg::S_FIND_RD;
        end
      end
      rsct_pkg::S_FIND_DONE: begin
        if (q.mode == rsct_pkg::MODE_UPDATE) begin
          if (hit) begin
            idx_next   = pos;
            state_next = rsct_pkg::S_DEL_RD;
          end else if (cnt == CW'(DEPTH)) begin
            res_next   = '{rsct_pkg::STATUS_FULL, 7'd0, q.player_id, 64'sd0, 1'b1};
            state_next = rsct_pkg::S_EMIT;
          end else begin
            idx_next   = '0;
            state_next = rsct_pkg::S_INS_RD;
          end
        end else if (!hit) begin
          res_next   = '{rsct_pkg::STATUS_NOTFOUND, 7'd0, q.player_id, 64'sd0, 1'b1};
          state_next = rsct_pkg::S_EMIT;
        end else begin
          res_next   = '{rsct_pkg::STATUS_OK, 7'(pos) + 7'd1, q.player_id, old, 1'b1};
          idx_next   = pos;
          state_next = (q.mode == rsct_pkg::MODE_REMOVE) ? rsct_pkg::S_DEL_RD
                                                         : rsct_pkg::S_EMIT;
        end
      end
      rsct_pkg::S_DEL_RD: begin
        if (idx_inc >= cnt) begin
          cnt_next = cnt - CW'(1);
          idx_next = '0;
          state_next = (q.mode == rsct_pkg::MODE_REMOVE) ? rsct_pkg::S_EMIT
                                                         : rsct_pkg::S_INS_RD;
        end else begin
          state_next = rsct_pkg::S_DEL_WR;
        end
      end
      rsct_pkg::S_DEL_WR: begin
        idx_next   = idx_inc;
        state_next = rsct_pkg::S_DEL_RD;
      end
      rsct_pkg::S_INS_RD: begin
        if (idx >= cnt) begin
          pos_next   = idx;
          state_next = rsct_pkg::S_SH_RD;
        end else begin
          state_next = rsct_pkg::S_INS_CHK;
        end
      end
      rsct_pkg::S_INS_CHK: begin
        if (ram_rdata.score >= q.score) begin
          idx_next   = idx_inc;
          state_next = rsct_pkg::S_INS_RD;
        end else begin
          pos_next   = idx;
          idx_next   = cnt;
          state_next = rsct_pkg::S_SH_RD;
        end
      end
      rsct_pkg::S_SH_RD: begin
        if (idx == pos) begin
          cnt_next   = cnt + CW'(1);
          res_next   = '{rsct_pkg::STATUS_OK, 7'(pos) + 7'd1, q.player_id, q.score, 1'b1};
          state_next = rsct_pkg::S_EMIT;
        end else begin
          state_next = rsct_pkg::S_SH_WR;
        end
      end
      rsct_pkg::S_SH_WR: begin
        idx_next   = idx_dec;
        state_next = rsct_pkg::S_SH_RD;
      end
      rsct_pkg::S_TOP_RD: state_next = rsct_pkg::S_TOP_CHK;
      rsct_pkg::S_TOP_CHK: begin
        res_next   = '{rsct_pkg::STATUS_OK, 7'(idx) + 7'd1, ram_rdata.id, ram_rdata.score,
                       idx_inc == n_top};
        state_next = rsct_pkg::S_EMIT;
      end
      rsct_pkg::S_EMIT: begin
        if (out_free) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          if (q.mode == rsct_pkg::MODE_TOP && !res.last) begin
            idx_next   = idx_inc;
            state_next = rsct_pkg::S_TOP_RD;
          end else begin
            state_next = rsct_pkg::S_IDLE;
          end
        end
      end
      default: state_next = rsct_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (state != rsct_pkg::S_IDLE);
    ram_re    = 1'b0;
    ram_raddr = idx[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = idx[AW-1:0];
    ram_wdata = ram_rdata;
    case (state)
      rsct_pkg::S_FIND_RD, rsct_pkg::S_INS_RD, rsct_pkg::S_TOP_RD: begin
        ram_re = 1'b1;
      end
      rsct_pkg::S_DEL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_inc[AW-1:0];
      end
      rsct_pkg::S_SH_RD: begin
        if (idx == pos) begin
          ram_we    = 1'b1;
          ram_wdata = '{q.player_id, q.score};
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec[AW-1:0];
        end
      end
      rsct_pkg::S_DEL_WR, rsct_pkg::S_SH_WR: begin
        ram_we = 1'b1;
      end
      default: ram_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rsct_pkg::S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      rsp_valid <= rsp_valid_next;
    end
    q     <= q_next;
    res   <= res_next;
    rsp   <= rsp_next;
    idx   <= idx_next;
    pos   <= pos_next;
    n_top <= n_top_next;
    hit   <= hit_next;
    old   <= old_next;
  end

endmodule

FILE: sim/testbench.sv
// Testbench for the ranked score table: directed and random words checked against a local model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH = 64;
  localparam int IDLE_LIMIT = 20000;

  class rank_scoreboard;
    logic [31:0] ids[$];
    logic signed [63:0] scores[$];
    rsct_pkg::rsp_word_t pending[$];
    int errors;
    int checked;

    function void queue_expected(rsct_pkg::rsp_word_t r);
      pending.insert(pending.size(), r);
    endfunction

    function int find_id(logic [31:0] id);
      foreach (ids[i]) if (ids[i] == id) return i;
      return -1;
    endfunction

    function void insert_sorted(logic [31:0] id, logic signed [63:0] s, output int p);
      p = 0;
      while (p < ids.size() && scores[p] >= s) p++;
      ids.insert(p, id);
      scores.insert(p, s);
    endfunction

    function rsct_pkg::rsp_word_t mk(logic [1:0] st, int rk, logic [31:0] id,
                                     logic signed [63:0] s, bit lst);
      rsct_pkg::rsp_word_t r;
      r.status = st; r.rank = rk[6:0]; r.entry_id = id; r.entry_score = s; r.last = lst;
      return r;
    endfunction

    function void note_request(rsct_pkg::req_word_t w);
      int pos, p, n;
      logic signed [63:0] old;
      pos = find_id(w.player_id);
      case (w.mode)
        rsct_pkg::MODE_UPDATE: begin
          if (pos >= 0) begin
            ids.delete(pos); scores.delete(pos);
          end else if (ids.size() >= TBL_DEPTH) begin
            queue_expected(mk(rsct_pkg::STATUS_FULL, 0, w.player_id, 0, 1));
            return;
          end
          insert_sorted(w.player_id, w.score, p);
          queue_expected(mk(rsct_pkg::STATUS_OK, p + 1, w.player_id, w.score, 1));
        end
        rsct_pkg::MODE_REMOVE, rsct_pkg::MODE_RANK: begin
          if (pos < 0) queue_expected(mk(rsct_pkg::STATUS_NOTFOUND, 0, w.player_id, 0, 1));
          else begin
            old = scores[pos];
            if (w.mode == rsct_pkg::MODE_REMOVE) begin
              ids.delete(pos); scores.delete(pos);
            end
            queue_expected(mk(rsct_pkg::STATUS_OK, pos + 1, w.player_id, old, 1));
          end
        end
        default: begin
          if (ids.size() == 0) queue_expected(mk(rsct_pkg::STATUS_NOTFOUND, 0, 0, 0, 1));
          else begin
            n = (w.top_count < ids.size()) ? w.top_count : ids.size();
            for (int i = 0; i < n; i++)
              queue_expected(mk(rsct_pkg::STATUS_OK, i + 1, ids[i], scores[i], i + 1 == n));
          end
        end
      endcase
    endfunction

    function void check_result(rsct_pkg::rsp_word_t got);
      rsct_pkg::rsp_word_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result word %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d got %0d", e.status, got.status); errors++;
      end
      if (got.rank !== e.rank) begin
        $error("rank: expected %0d got %0d", e.rank, got.rank); errors++;
      end
      if (got.entry_id !== e.entry_id) begin
        $error("entry_id: expected %0h got %0h", e.entry_id, got.entry_id); errors++;
      end
      if (got.entry_score !== e.entry_score) begin
        $error("entry_score: expected %0d got %0d", e.entry_score, got.entry_score);
        errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall;
  rsct_pkg::req_word_t req;
  rsct_pkg::rsp_word_t rsp;
  rank_scoreboard board;
  int sent, idle_cycles;
  bit long_hold;
  logic [31:0] id_pool[8];

  ranked_score_table #(.DEPTH(TBL_DEPTH)) DUT (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) board.note_request(req);
      if (rsp_valid && !rsp_stall) board.check_result(rsp);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", board.pending.size());
        $display("[ranked_score_table] ERROR");
        $finish;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    rsp_stall = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        rsp_stall <= 1;
        repeat (600) @(negedge clk);
        long_hold = 0;
        rsp_stall <= 0;
      end else begin
        case ($urandom_range(0, 3))
          0: rsp_stall <= 1;
          1: rsp_stall <= ($urandom_range(0, 9) < 3);
          default: rsp_stall <= 0;
        endcase
      end
    end
  end

  task automatic send(rsct_pkg::req_word_t w);
    req <= w;
    req_valid <= 1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic gap();
    req_valid <= 0;
    repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  function automatic rsct_pkg::req_word_t word(logic [1:0] m, logic [31:0] id,
                                               logic signed [63:0] s, logic [6:0] tc);
    rsct_pkg::req_word_t w;
    w.mode = m; w.player_id = id; w.score = s; w.top_count = tc;
    return w;
  endfunction

  function automatic logic signed [63:0] rand_score();
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      1: return 64'sh7FFFFFFFFFFFFFFF;
      2: return 64'sh8000000000000000;
      default: return $signed(64'($urandom_range(0, 6))) - 3;
    endcase
  endfunction

  function automatic logic [31:0] rand_id();
    return ($urandom_range(0, 5) == 0) ? $urandom : id_pool[$urandom_range(0, 7)];
  endfunction

  task automatic drain();
    req_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    int burst;
    board = new();
    rst = 1; req_valid = 0; req = '0; sent = 0; idle_cycles = 0; long_hold = 0;
    foreach (id_pool[i]) id_pool[i] = (i == 0) ? 32'hFFFFFFFF : (i == 1) ? 0 : $urandom;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty table, extremes, ties, full table
    send(word(rsct_pkg::MODE_TOP, 1, 0, 0));
    send(word(rsct_pkg::MODE_TOP, 1, 0, 7'h7F));
    send(word(rsct_pkg::MODE_RANK, 32'hFFFFFFFF, 0, 0));
    send(word(rsct_pkg::MODE_REMOVE, 5, 0, 0));
    send(word(rsct_pkg::MODE_UPDATE, 32'hFFFFFFFF, 64'sh7FFFFFFFFFFFFFFF, 7'h7F));
    send(word(rsct_pkg::MODE_UPDATE, 0, 64'sh8000000000000000, 0));
    send(word(rsct_pkg::MODE_UPDATE, 7, 5, 0));
    send(word(rsct_pkg::MODE_UPDATE, 8, 5, 0));
    send(word(rsct_pkg::MODE_UPDATE, 7, 5, 0));
    send(word(rsct_pkg::MODE_TOP, 0, 0, 0));
    send(word(rsct_pkg::MODE_TOP, 0, 0, 2));
    send(word(rsct_pkg::MODE_TOP, 0, 0, 7'h7F));
    send(word(rsct_pkg::MODE_RANK, 8, 0, 0));
    send(word(rsct_pkg::MODE_REMOVE, 8, 0, 0));
    send(word(rsct_pkg::MODE_REMOVE, 8, 0, 0));
    for (int i = 0; i < TBL_DEPTH; i++)
      send(word(rsct_pkg::MODE_UPDATE, 32'h1000 + i,
                $signed(64'($urandom_range(0, 9))), 0));
    send(word(rsct_pkg::MODE_UPDATE, 32'h5555AAAA, 1, 0));
    send(word(rsct_pkg::MODE_TOP, 0, 0, 64));
    send(word(rsct_pkg::MODE_RANK, 32'h1000 + 63, 0, 0));
    drain();
    for (int i = 0; i < TBL_DEPTH; i++)
      send(word(rsct_pkg::MODE_REMOVE, 32'h1000 + i, 0, 0));

    // receiver holds off while the sender keeps offering
    long_hold = 1;
    for (int i = 0; i < 12; i++)
      send(word(rsct_pkg::MODE_RANK, rand_id(), rand_score(), 0));
    drain();

    while (sent < 350) begin
      burst = $urandom_range(1, 15);
      for (int i = 0; i < burst; i++) begin
        rsct_pkg::req_word_t w;
        w = word(2'($urandom_range(0, 3)), rand_id(), rand_score(),
                 7'($urandom_range(0, 127)));
        if (w.mode == rsct_pkg::MODE_TOP && $urandom_range(0, 3) != 0)
          w.top_count = 7'($urandom_range(0, 6));
        if ($urandom_range(0, 2) == 0) w.mode = rsct_pkg::MODE_UPDATE;
        send(w);
      end
      if ($urandom_range(0, 9) == 0) drain();
      else gap();
    end
    drain();
    repeat (500) @(negedge clk);

    $display("sent %0d request words, checked %0d result words", sent, board.checked);
    $display("covered score extremes, ties, full-table drops, empty and clipped top reads");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[ranked_score_table] OK");
    else
      $display("[ranked_score_table] ERROR");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/rsct_pkg.sv
rtl/rsct_ram.sv
rtl/ranked_score_table.sv
sim/testbench.sv
